>>> design/ssda_pkg.sv
// ----------------------------------------------------------------------------
// ssda_pkg
// Shared widths, register indexes, angle constants and the arctangent table
// for the segment select and direction angle core.
// ----------------------------------------------------------------------------
package ssda_pkg;

  // Default geometry
  localparam int COORD_BITS_DEF = 10;
  localparam int ANGLE_FRAC_DEF = 8;

  // Configuration port
  localparam int REG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_RADIUS = 2'd2;
  localparam logic [REG_W-1:0] CENTER_X_RST    = 10'd200;
  localparam logic [REG_W-1:0] CENTER_Y_RST    = 10'd200;
  localparam logic [REG_W-1:0] NEAR_RADIUS_RST = 10'd100;

  // Result field widths
  localparam int ANGLE_W = 17;
  localparam int LEN_W   = 11;
  localparam int PT_W    = 10;

  // Angle arithmetic: degrees scaled by 2^INT_FRAC
  localparam int INT_FRAC     = 20;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam int PRESCALE     = 24;
  localparam int ZW           = 29;
  localparam int OCT_W        = 26;
  localparam int FULL_W       = 29;
  localparam int DEG45_I      = 45 * (2 ** INT_FRAC);
  localparam int DEG90_I      = 90 * (2 ** INT_FRAC);
  localparam int DEG180_I     = 180 * (2 ** INT_FRAC);
  localparam int DEG360_I     = 360 * (2 ** INT_FRAC);

  // atan(2^-i) in 2^-20 degree, rounded to nearest
  function automatic logic [OCT_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [OCT_W-1:0] v;
    case (idx)
      5'd0:    v = 26'd47185920;
      5'd1:    v = 26'd27855475;
      5'd2:    v = 26'd14718068;
      5'd3:    v = 26'd7471121;
      5'd4:    v = 26'd3750058;
      5'd5:    v = 26'd1876857;
      5'd6:    v = 26'd938658;
      5'd7:    v = 26'd469357;
      5'd8:    v = 26'd234682;
      5'd9:    v = 26'd117342;
      5'd10:   v = 26'd58671;
      5'd11:   v = 26'd29335;
      5'd12:   v = 26'd14668;
      5'd13:   v = 26'd7334;
      5'd14:   v = 26'd3667;
      5'd15:   v = 26'd1833;
      5'd16:   v = 26'd917;
      5'd17:   v = 26'd458;
      5'd18:   v = 26'd229;
      5'd19:   v = 26'd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> design/ssda_isqrt.sv
// ----------------------------------------------------------------------------
// ssda_isqrt
// Digit-serial integer square root: two radicand bits enter and one root
// bit leaves per cycle, restoring form.
// ----------------------------------------------------------------------------
module ssda_isqrt import ssda_pkg::*; #(
  parameter int ROOT_W = COORD_BITS_DEF + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 1;
  localparam int TRY_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [TRY_W-1:0]  cat, sub, trial;
  logic              take;

  // One root digit: bring down two bits, try subtracting 4*root+1
  always_comb begin
    cat      = {rem_r, rad_r[RAD_W-1 -: 2]};
    sub      = {1'b0, root_r, 2'b01};
    take     = (cat >= sub);
    trial    = cat - sub;
    rem_nxt  = take ? trial[REM_W-1:0] : cat[REM_W-1:0];
    root_nxt = {root_r[ROOT_W-2:0], take};
  end

  // Load, then shift one digit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(ROOT_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> design/ssda_cordic.sv
// ----------------------------------------------------------------------------
// ssda_cordic
// Vectoring CORDIC for the first-octant angle atan(b/a), one micro-rotation
// per cycle, result in 2^-20 degree clamped to 0..45 degrees.
// ----------------------------------------------------------------------------
module ssda_cordic import ssda_pkg::*; #(
  parameter int COORD_W = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COORD_W-1:0] a,
  input  logic [COORD_W-1:0] b,
  output logic               done,
  output logic [OCT_W-1:0]   oct
);

  localparam int XW = COORD_W + PRESCALE + 3;
  localparam logic signed [ZW-1:0] DEG45_Z = ZW'(DEG45_I);

  logic signed [XW-1:0] x_r, y_r, x_sh, y_sh, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt, z_clamp, tab;
  logic [STEP_W-1:0]    cnt_r;
  logic                 busy_r, done_r, y_pos;

  // Micro-rotation toward the x axis
  always_comb begin
    x_sh  = x_r >>> cnt_r;
    y_sh  = y_r >>> cnt_r;
    tab   = signed'({{(ZW-OCT_W){1'b0}}, atan_lut(cnt_r)});
    y_pos = !y_r[XW-1] && (y_r != '0);
    if (y_pos) begin
      x_nxt = x_r + y_sh;
      y_nxt = y_r - x_sh;
      z_nxt = z_r + tab;
    end else begin
      x_nxt = x_r - y_sh;
      y_nxt = y_r + x_sh;
      z_nxt = z_r - tab;
    end
    if (z_nxt[ZW-1]) begin
      z_clamp = '0;
    end else if (z_nxt > DEG45_Z) begin
      z_clamp = DEG45_Z;
    end else begin
      z_clamp = z_nxt;
    end
  end

  // Load operands, settle flat and diagonal cases at once, else iterate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r   <= signed'({3'b000, a, {PRESCALE{1'b0}}});
        y_r   <= signed'({3'b000, b, {PRESCALE{1'b0}}});
        z_r   <= '0;
        cnt_r <= '0;
        if (b == '0) begin
          done_r <= 1'b1;
        end else if (a == b) begin
          z_r    <= DEG45_Z;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        x_r   <= x_nxt;
        y_r   <= y_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
          z_r    <= z_clamp;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          z_r <= z_nxt;
        end
      end
    end
  end

  assign done = done_r;
  assign oct  = z_r[OCT_W-1:0];

endmodule

>>> design/segment_select_direction_angle_core.sv
// ----------------------------------------------------------------------------
// segment_select_direction_angle_core
// Keeps the longest segment near the centre over a set of segments and, on
// the last one, reports it with its start endpoint and direction angle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
//  in      | in        | in_valid/ready     | two endpoints, last_segment
//  out     | out       | out_valid/ready    | found, angle, start, length, ends
//
//  A segment's time is set by the bit-serial square root
//  (one root bit per cycle).
//  A last segment adds two distance squares, then the 20-step CORDIC;
//  flat or diagonal segments skip the CORDIC iterations.
//  Reset loads the centre 200,200 and radius 100 and drops any kept segment.
//  A waiting result does not block intake; only a last segment holds until
//  the output register is free.
// ----------------------------------------------------------------------------
module segment_select_direction_angle_core import ssda_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_first_x,
  input  logic [COORD_BITS-1:0] in_first_y,
  input  logic [COORD_BITS-1:0] in_second_x,
  input  logic [COORD_BITS-1:0] in_second_y,
  input  logic                  in_last_segment,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [ANGLE_W-1:0]    out_angle_q8,
  output logic                  out_start_is_second,
  output logic [LEN_W-1:0]      out_best_length,
  output logic [PT_W-1:0]       out_best_first_x,
  output logic [PT_W-1:0]       out_best_first_y,
  output logic [PT_W-1:0]       out_best_second_x,
  output logic [PT_W-1:0]       out_best_second_y
);

  localparam int C      = COORD_BITS;
  localparam int ROOT_W = C + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int MW     = (C > REG_W) ? C : REG_W;
  localparam int DW     = MW + 1;
  localparam int SQW    = 2 * MW + 1;
  localparam int SH     = INT_FRAC - ANGLE_FRAC_BITS;
  localparam int QW     = FULL_W + 1 - SH;
  localparam logic [QW-1:0]     WRAP_Q = QW'(360 * (2 ** ANGLE_FRAC_BITS));
  localparam logic [FULL_W:0]   ROUND  = (FULL_W+1)'(2 ** (SH - 1));
  localparam logic [FULL_W-1:0] DEG90  = FULL_W'(DEG90_I);
  localparam logic [FULL_W-1:0] DEG180 = FULL_W'(DEG180_I);
  localparam logic [FULL_W-1:0] DEG360 = FULL_W'(DEG360_I);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SQLEN  = 4'd1;
  localparam logic [3:0] ST_SQRT   = 4'd2;
  localparam logic [3:0] ST_DIST1  = 4'd3;
  localparam logic [3:0] ST_DIST2  = 4'd4;
  localparam logic [3:0] ST_ORIENT = 4'd5;
  localparam logic [3:0] ST_ROT    = 4'd6;
  localparam logic [3:0] ST_PHI    = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [REG_W-1:0]  cx_r, cy_r, nr_r;
  logic [C-1:0]      x1_r, y1_r, x2_r, y2_r;
  logic              last_r, cand_r, cand_nxt;
  logic              have_r, have_nxt, upd;
  logic [ROOT_W-1:0] klen_r;
  logic [C-1:0]      kx1_r, ky1_r, kx2_r, ky2_r;
  logic [SQW-1:0]    s1_r;
  logic              sel_r, swap_r, negx_r, negy_r;
  logic [FULL_W-1:0] full_r, phi, full_nxt;
  logic              out_valid_r;
  logic              fin_go;

  logic [DW-1:0]        ea1, ea2, eb1, eb2;
  logic signed [DW-1:0] sq_a, sq_b;
  logic signed [2*DW-1:0] pa, pb;
  logic [SQW-1:0]       sq_sum;

  logic signed [C:0] ddx, ddy;
  logic [C:0]        adx_w, ady_w;
  logic [C-1:0]      adx, ady, cor_a, cor_b;
  logic              swap_w;

  logic [FULL_W:0]   q_sum;
  logic [QW-1:0]     q, q_wrap;

  logic              isq_start, isq_done, cor_start, cor_done;
  logic [ROOT_W-1:0] isq_root;
  logic [OCT_W-1:0]  cor_oct;

  // Per-axis nearness: |p - c| < r
  function automatic logic near_ax(input logic [MW-1:0] p, input logic [MW-1:0] c,
                                   input logic [MW-1:0] r);
    logic [MW-1:0] d;
    d = (p >= c) ? (p - c) : (c - p);
    return d < r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= CENTER_X_RST;
      cy_r <= CENTER_Y_RST;
      nr_r <= NEAR_RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X:    cx_r <= cfg_data;
        REG_CENTER_Y:    cy_r <= cfg_data;
        REG_NEAR_RADIUS: nr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Candidate test on the captured segment
  always_comb begin
    cand_nxt = (near_ax(MW'(x1_r), MW'(cx_r), MW'(nr_r)) &&
                near_ax(MW'(y1_r), MW'(cy_r), MW'(nr_r))) ||
               (near_ax(MW'(x2_r), MW'(cx_r), MW'(nr_r)) &&
                near_ax(MW'(y2_r), MW'(cy_r), MW'(nr_r)));
  end

  // Shared sum of squares: segment length, then the two centre distances
  always_comb begin
    case (state_r)
      ST_SQLEN: begin
        ea1 = DW'(x1_r);  ea2 = DW'(x2_r);
        eb1 = DW'(y2_r);  eb2 = DW'(y1_r);
      end
      ST_DIST1: begin
        ea1 = DW'(kx1_r); ea2 = DW'(cx_r);
        eb1 = DW'(ky1_r); eb2 = DW'(cy_r);
      end
      default: begin
        ea1 = DW'(kx2_r); ea2 = DW'(cx_r);
        eb1 = DW'(ky2_r); eb2 = DW'(cy_r);
      end
    endcase
    sq_a   = signed'(ea1 - ea2);
    sq_b   = signed'(eb1 - eb2);
    pa     = sq_a * sq_a;
    pb     = sq_b * sq_b;
    sq_sum = {1'b0, pa[2*MW-1:0]} + {1'b0, pb[2*MW-1:0]};
  end

  assign isq_start = (state_r == ST_SQLEN);
  assign cor_start = (state_r == ST_ORIENT);

  ssda_isqrt #(.ROOT_W(ROOT_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (isq_start),
    .radicand (RAD_W'(sq_sum)),
    .done     (isq_done),
    .root     (isq_root)
  );

  // Keep the first of the longest candidates
  assign upd      = cand_r && (!have_r || (isq_root > klen_r));
  assign have_nxt = have_r || upd;

  // Offsets from the start endpoint, folded for the CORDIC
  always_comb begin
    if (sel_r) begin
      ddx = signed'({1'b0, kx1_r} - {1'b0, kx2_r});
      ddy = signed'({1'b0, ky2_r} - {1'b0, ky1_r});
    end else begin
      ddx = signed'({1'b0, kx2_r} - {1'b0, kx1_r});
      ddy = signed'({1'b0, ky1_r} - {1'b0, ky2_r});
    end
    adx_w  = ddx[C] ? (~ddx + 1'b1) : ddx;
    ady_w  = ddy[C] ? (~ddy + 1'b1) : ddy;
    adx    = adx_w[C-1:0];
    ady    = ady_w[C-1:0];
    swap_w = (ady > adx);
    cor_a  = swap_w ? ady : adx;
    cor_b  = swap_w ? adx : ady;
  end

  ssda_cordic #(.COORD_W(C)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .a     (cor_a),
    .b     (cor_b),
    .done  (cor_done),
    .oct   (cor_oct)
  );

  // Unfold the octant angle to the full circle
  always_comb begin
    phi = swap_r ? (DEG90 - FULL_W'(cor_oct)) : FULL_W'(cor_oct);
    case ({negx_r, negy_r})
      2'b00:   full_nxt = phi;
      2'b10:   full_nxt = DEG180 - phi;
      2'b11:   full_nxt = DEG180 + phi;
      2'b01:   full_nxt = DEG360 - phi;
      default: full_nxt = phi;
    endcase
  end

  // Round half up to the output step, wrap a full turn to zero
  always_comb begin
    q_sum  = {1'b0, full_r} + ROUND;
    q      = q_sum[FULL_W:SH];
    q_wrap = (q >= WRAP_Q) ? (q - WRAP_Q) : q;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SQLEN;
      ST_SQLEN:  state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (isq_done) begin
          if (!last_r)       state_nxt = ST_IDLE;
          else if (have_nxt) state_nxt = ST_DIST1;
          else               state_nxt = ST_FIN;
        end
      end
      ST_DIST1:  state_nxt = ST_DIST2;
      ST_DIST2:  state_nxt = ST_ORIENT;
      ST_ORIENT: state_nxt = ST_ROT;
      ST_ROT:    if (cor_done) state_nxt = ST_PHI;
      ST_PHI:    state_nxt = ST_FIN;
      ST_FIN:    if (fin_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_SQRT) && isq_done) begin
        have_r <= have_nxt;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
        have_r      <= 1'b0;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x1_r   <= in_first_x;
      y1_r   <= in_first_y;
      x2_r   <= in_second_x;
      y2_r   <= in_second_y;
      last_r <= in_last_segment;
    end
    if (state_r == ST_SQLEN) begin
      cand_r <= cand_nxt;
    end
    if ((state_r == ST_SQRT) && isq_done && upd) begin
      klen_r <= isq_root;
      kx1_r  <= x1_r;
      ky1_r  <= y1_r;
      kx2_r  <= x2_r;
      ky2_r  <= y2_r;
    end
    if (state_r == ST_DIST1) begin
      s1_r <= sq_sum;
    end
    if (state_r == ST_DIST2) begin
      sel_r <= (s1_r >= sq_sum);
    end
    if (state_r == ST_ORIENT) begin
      swap_r <= swap_w;
      negx_r <= ddx[C];
      negy_r <= ddy[C];
    end
    if (state_r == ST_PHI) begin
      full_r <= full_nxt;
    end
    if (fin_go) begin
      out_found <= have_r;
      if (have_r) begin
        out_angle_q8        <= ANGLE_W'(q_wrap);
        out_start_is_second <= sel_r;
        out_best_length     <= LEN_W'(klen_r);
        out_best_first_x    <= PT_W'(kx1_r);
        out_best_first_y    <= PT_W'(ky1_r);
        out_best_second_x   <= PT_W'(kx2_r);
        out_best_second_y   <= PT_W'(ky2_r);
      end else begin
        out_angle_q8        <= '0;
        out_start_is_second <= 1'b0;
        out_best_length     <= '0;
        out_best_first_x    <= '0;
        out_best_first_y    <= '0;
        out_best_second_x   <= '0;
        out_best_second_y   <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_isq_done_in_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    isq_done |-> state_r == ST_SQRT) else $error("square root done outside SQRT");

  a_cor_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> state_r == ST_ROT) else $error("CORDIC done outside ROT");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> !have_r && out_valid) else $error("set close left state behind");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_angle_q8 == '0 && out_best_length == '0)
    else $error("empty result carries data");
`endif

endmodule

>>> tb/segment_select_direction_angle_core_tb.sv
// ----------------------------------------------------------------------------
// segment_select_direction_angle_core_tb
// Streams sets of line segments into the core, with the centre and the near
// radius changed between phases, and checks every reported pick (found flag,
// start endpoint, length, endpoints and direction angle) against a
// cycle-free model of the selection and the CORDIC angle. Sender gaps,
// receiver stalls and one long output hold-off are applied along the way.
// ----------------------------------------------------------------------------
module segment_select_direction_angle_core_tb import ssda_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_BITS_DEF;
  localparam int COORD_MAX = (1 << CW) - 1;
  localparam int SETTLE_CYCLES = 100;

  // atan(2^-i) in 2^-20 degree
  localparam longint ANGLE_STEP_Q20 [CORDIC_STEPS] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
    469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115
  };

  typedef struct packed {
    logic [CW-1:0] fx;
    logic [CW-1:0] fy;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic          last;
  } seg_t;

  typedef struct packed {
    logic               found;
    logic [ANGLE_W-1:0] angle;
    logic               start_second;
    logic [LEN_W-1:0]   length;
    logic [PT_W-1:0]    fx;
    logic [PT_W-1:0]    fy;
    logic [PT_W-1:0]    sx;
    logic [PT_W-1:0]    sy;
  } pick_t;

  // Tracks the longest near segment of the open set and queues the picks
  class pick_scoreboard;
    logic [REG_W-1:0] reg_cx;
    logic [REG_W-1:0] reg_cy;
    logic [REG_W-1:0] reg_radius;
    bit               have_kept;
    longint           kept_len;
    seg_t             kept;
    pick_t            pending_picks[$];
    int               mismatches;
    int               picks_seen;

    function new();
      reg_cx     = CENTER_X_RST;
      reg_cy     = CENTER_Y_RST;
      reg_radius = NEAR_RADIUS_RST;
      have_kept  = 1'b0;
      kept_len   = 0;
      kept       = '0;
      mismatches = 0;
      picks_seen = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] v);
      case (idx)
        REG_CENTER_X:    reg_cx = v;
        REG_CENTER_Y:    reg_cy = v;
        REG_NEAR_RADIUS: reg_radius = v;
        default: ;
      endcase
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint isqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    // Vectoring CORDIC on the folded offsets, 0 <= b <= a
    function longint octant_q20(longint a, longint b);
      longint x;
      longint y;
      longint z;
      longint nx;
      int     i;
      if (b == 0) return 0;
      if (a == b) return longint'(DEG45_I);
      x = a <<< PRESCALE;
      y = b <<< PRESCALE;
      z = 0;
      for (i = 0; i < CORDIC_STEPS; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + ANGLE_STEP_Q20[i];
        end else begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - ANGLE_STEP_Q20[i];
        end
        x = nx;
      end
      if (z < 0) z = 0;
      if (z > longint'(DEG45_I)) z = longint'(DEG45_I);
      return z;
    endfunction

    // Direction of (dx, dy-up) in 2^-ANGLE_FRAC degree, wrapped to [0, 360)
    function longint heading_q8(longint dx, longint dy);
      longint ax;
      longint ay;
      longint phi;
      longint full;
      longint q;
      int     sh;
      ax = mag(dx);
      ay = mag(dy);
      if (ay > ax) phi = longint'(DEG90_I) - octant_q20(ay, ax);
      else phi = octant_q20(ax, ay);
      if (dx >= 0 && dy >= 0) full = phi;
      else if (dx < 0 && dy >= 0) full = longint'(DEG180_I) - phi;
      else if (dx < 0) full = longint'(DEG180_I) + phi;
      else full = longint'(DEG360_I) - phi;
      sh = INT_FRAC - ANGLE_FRAC_DEF;
      q = (full + (longint'(1) <<< (sh - 1))) >>> sh;
      if (q >= (longint'(360) <<< ANGLE_FRAC_DEF)) q = q - (longint'(360) <<< ANGLE_FRAC_DEF);
      return q;
    endfunction

    function bit is_near(longint x, longint y);
      return mag(x - longint'(reg_cx)) < longint'(reg_radius) &&
             mag(y - longint'(reg_cy)) < longint'(reg_radius);
    endfunction

    // Update the kept segment; close the set on a last segment
    function void note_segment(seg_t s);
      longint x1;
      longint y1;
      longint x2;
      longint y2;
      longint dx;
      longint dy;
      longint len;
      longint s1;
      longint s2;
      pick_t  p;
      x1 = longint'(s.fx);
      y1 = longint'(s.fy);
      x2 = longint'(s.sx);
      y2 = longint'(s.sy);
      if (is_near(x1, y1) || is_near(x2, y2)) begin
        dx  = x1 - x2;
        dy  = y2 - y1;
        len = isqrt(longint'(unsigned'(dx * dx + dy * dy)));
        if (!have_kept || len > kept_len) begin
          have_kept = 1'b1;
          kept_len  = len;
          kept      = s;
        end
      end
      if (!s.last) return;

      p = '0;
      if (have_kept) begin
        x1 = longint'(kept.fx);
        y1 = longint'(kept.fy);
        x2 = longint'(kept.sx);
        y2 = longint'(kept.sy);
        s1 = (x1 - longint'(reg_cx)) * (x1 - longint'(reg_cx)) +
             (y1 - longint'(reg_cy)) * (y1 - longint'(reg_cy));
        s2 = (x2 - longint'(reg_cx)) * (x2 - longint'(reg_cx)) +
             (y2 - longint'(reg_cy)) * (y2 - longint'(reg_cy));
        p.found = 1'b1;
        if (s1 < s2) begin
          p.angle        = ANGLE_W'(heading_q8(x2 - x1, y1 - y2));
          p.start_second = 1'b0;
        end else begin
          p.angle        = ANGLE_W'(heading_q8(x1 - x2, y2 - y1));
          p.start_second = 1'b1;
        end
        p.length = LEN_W'(kept_len);
        p.fx     = PT_W'(kept.fx);
        p.fy     = PT_W'(kept.fy);
        p.sx     = PT_W'(kept.sx);
        p.sy     = PT_W'(kept.sy);
      end
      pending_picks.push_back(p);
      have_kept = 1'b0;
      kept_len  = 0;
      kept      = '0;
    endfunction

    function void flag_field(string what, longint want, longint seen);
      if (want != seen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH pick %0d %s: expected %0d, got %0d",
                   picks_seen, what, want, seen);
      end
    endfunction

    function void check_pick(pick_t got);
      pick_t want;
      picks_seen++;
      if (pending_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH pick %0d arrived with no set closed", picks_seen);
        return;
      end
      want = pending_picks.pop_front();
      flag_field("found", longint'(want.found), longint'(got.found));
      flag_field("angle_q8", longint'(want.angle), longint'(got.angle));
      flag_field("start_is_second", longint'(want.start_second),
                 longint'(got.start_second));
      flag_field("best_length", longint'(want.length), longint'(got.length));
      flag_field("best_first_x", longint'(want.fx), longint'(got.fx));
      flag_field("best_first_y", longint'(want.fy), longint'(got.fy));
      flag_field("best_second_x", longint'(want.sx), longint'(got.sx));
      flag_field("best_second_y", longint'(want.sy), longint'(got.sy));
    endfunction

    function int open_count();
      return pending_picks.size();
    endfunction

    function int close_out();
      if (pending_picks.size() != 0 && mismatches < 10)
        $display("MISMATCH %0d picks never reported", pending_picks.size());
      return mismatches + pending_picks.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [CW-1:0]        in_first_x;
  logic [CW-1:0]        in_first_y;
  logic [CW-1:0]        in_second_x;
  logic [CW-1:0]        in_second_y;
  logic                 in_last_segment;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_found;
  logic [ANGLE_W-1:0]   out_angle_q8;
  logic                 out_start_is_second;
  logic [LEN_W-1:0]     out_best_length;
  logic [PT_W-1:0]      out_best_first_x;
  logic [PT_W-1:0]      out_best_first_y;
  logic [PT_W-1:0]      out_best_second_x;
  logic [PT_W-1:0]      out_best_second_y;

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_left;

  pick_scoreboard board = new();

  segment_select_direction_angle_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_first_x          (in_first_x),
    .in_first_y          (in_first_y),
    .in_second_x         (in_second_x),
    .in_second_y         (in_second_y),
    .in_last_segment     (in_last_segment),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_found           (out_found),
    .out_angle_q8        (out_angle_q8),
    .out_start_is_second (out_start_is_second),
    .out_best_length     (out_best_length),
    .out_best_first_x    (out_best_first_x),
    .out_best_first_y    (out_best_first_y),
    .out_best_second_x   (out_best_second_x),
    .out_best_second_y   (out_best_second_y)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Track register writes and segment transactions as the core takes them
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) board.write_register(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_segment('{in_first_x, in_first_y, in_second_x, in_second_y,
                           in_last_segment});
  end

  // Check each pick transaction in order
  always @(posedge clk) begin : pick_monitor
    pick_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.found        = out_found;
      seen.angle        = out_angle_q8;
      seen.start_second = out_start_is_second;
      seen.length       = out_best_length;
      seen.fx           = out_best_first_x;
      seen.fy           = out_best_first_y;
      seen.sx           = out_best_second_x;
      seen.sy           = out_best_second_y;
      board.check_pick(seen);
    end
  end

  // Receiver: long hold-off when requested, otherwise random stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready = (recv_stall_pct == 0) ||
                    (int'($urandom_range(99)) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [CW-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return CW'(COORD_MAX);
    return CW'(v);
  endfunction

  function automatic logic [CW-1:0] near_coord(int c, int r);
    int off;
    off = int'($urandom_range(r));
    return clamp_coord(($urandom_range(1) == 1) ? c + off : c - off);
  endfunction

  function automatic seg_t make_seg(int fx, int fy, int sx, int sy, bit last);
    seg_t s;
    s.fx   = CW'(fx);
    s.fy   = CW'(fy);
    s.sx   = CW'(sx);
    s.sy   = CW'(sy);
    s.last = last;
    return s;
  endfunction

  // Mostly segments touching the near box, plus noise, flat/diagonal
  // segments and endpoints right on the radius boundary
  function automatic seg_t random_segment();
    seg_t s;
    int   cx;
    int   cy;
    int   r;
    int   kind;
    int   shape;
    int   sgx;
    int   sgy;
    int   lim;
    int   d;
    logic [CW-1:0] t;
    cx   = int'(board.reg_cx);
    cy   = int'(board.reg_cy);
    r    = int'(board.reg_radius);
    kind = int'($urandom_range(99));
    s.fx = near_coord(cx, r);
    s.fy = near_coord(cy, r);
    s.sx = CW'($urandom_range(COORD_MAX));
    s.sy = CW'($urandom_range(COORD_MAX));
    s.last = 1'b0;
    if (kind < 55) begin
      if ($urandom_range(1) == 1) begin
        s.sx = near_coord(cx, r + 40);
        s.sy = near_coord(cy, r + 40);
      end
    end else if (kind < 75) begin
      s.fx = CW'($urandom_range(COORD_MAX));
      s.fy = CW'($urandom_range(COORD_MAX));
    end else if (kind < 88) begin
      shape = int'($urandom_range(2));
      if (shape == 0) s.sy = s.fy;
      else if (shape == 1) s.sx = s.fx;
      else begin
        sgx = ($urandom_range(1) == 1) ? 1 : -1;
        sgy = ($urandom_range(1) == 1) ? 1 : -1;
        lim = (sgx > 0) ? COORD_MAX - int'(s.fx) : int'(s.fx);
        d   = (sgy > 0) ? COORD_MAX - int'(s.fy) : int'(s.fy);
        if (d < lim) lim = d;
        d    = int'($urandom_range(lim));
        s.sx = CW'(int'(s.fx) + sgx * d);
        s.sy = CW'(int'(s.fy) + sgy * d);
      end
    end else begin
      d    = r + int'($urandom_range(2)) - 1;
      s.fx = clamp_coord(($urandom_range(1) == 1) ? cx + d : cx - d);
      d    = r + int'($urandom_range(2)) - 1;
      s.fy = clamp_coord(($urandom_range(1) == 1) ? cy + d : cy - d);
      if ($urandom_range(1) == 1) begin
        s.sx = s.fx;
        s.sy = s.fy;
      end
    end
    // Put the near endpoint on either side
    if ($urandom_range(1) == 1) begin
      t = s.fx; s.fx = s.sx; s.sx = t;
      t = s.fy; s.fy = s.sy; s.sy = t;
    end
    return s;
  endfunction

  // Offer one segment transaction; holds valid until it is taken
  task automatic send_segment(seg_t s);
    int gap;
    gap = 0;
    while (sender_idle_pct > 0 && int'($urandom_range(99)) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_first_x      = s.fx;
    in_first_y      = s.fy;
    in_second_x     = s.sx;
    in_second_y     = s.sy;
    in_last_segment = s.last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = REG_W'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(int cx, int cy, int r);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_NEAR_RADIUS, r);
  endtask

  // Drop valid, wait for every pick, then let the core go quiet
  task automatic settle();
    in_valid = 1'b0;
    while (board.open_count() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(int n_items);
    int   sent;
    int   size;
    int   i;
    seg_t s;
    sent = 0;
    while (sent < n_items) begin
      size = ($urandom_range(9) == 0) ? int'($urandom_range(12, 7))
                                      : int'($urandom_range(4, 1));
      for (i = 0; i < size; i++) begin
        s      = random_segment();
        s.last = (i == size - 1);
        send_segment(s);
        sent++;
      end
    end
  endtask

  // Directed sets at the reset centre (200,200) and radius 100
  task automatic directed_sets();
    // no candidate
    send_segment(make_seg(0, 0, 1023, 1023, 1));
    // axis-aligned and diagonal directions
    send_segment(make_seg(200, 200, 300, 200, 1));
    send_segment(make_seg(200, 200, 200, 100, 1));
    send_segment(make_seg(200, 200, 100, 200, 1));
    send_segment(make_seg(200, 200, 200, 300, 1));
    send_segment(make_seg(200, 200, 250, 150, 0));
    send_segment(make_seg(150, 150, 150, 150, 1));
    // zero length alone, equal distances pick the second endpoint
    send_segment(make_seg(150, 150, 150, 150, 1));
    // radius boundary: 99 away counts, 100 away does not
    send_segment(make_seg(299, 101, 1023, 1023, 0));
    send_segment(make_seg(300, 200, 0, 0, 0));
    send_segment(make_seg(1023, 0, 101, 299, 1));
    // tie keeps the earlier segment
    send_segment(make_seg(200, 200, 210, 200, 0));
    send_segment(make_seg(200, 200, 200, 210, 1));
    // a later longer segment wins
    send_segment(make_seg(190, 190, 195, 195, 0));
    send_segment(make_seg(180, 180, 230, 260, 0));
    send_segment(make_seg(100, 300, 199, 201, 1));
    // start at the second endpoint, other quadrants, field extremes
    send_segment(make_seg(1023, 1023, 200, 200, 1));
    send_segment(make_seg(0, 1023, 201, 199, 1));
    send_segment(make_seg(200, 200, 1023, 0, 1));
    send_segment(make_seg(199, 199, 0, 0, 1));
  endtask

  initial begin
    int i;
    seg_t s;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_CENTER_X;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_first_x      = '0;
    in_first_y      = '0;
    in_second_x     = '0;
    in_second_y     = '0;
    in_last_segment = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_left       = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_sets();
    settle();

    // centre at the origin, widest radius
    configure(0, 0, 1023);
    run_random(150);
    settle();

    // far corner, radius of one; sender idles
    sender_idle_pct = 50;
    configure(1023, 1023, 1);
    run_random(100);
    settle();

    // receiver stalls
    sender_idle_pct = 0;
    recv_stall_pct  = 50;
    configure(512, 300, 200);
    run_random(200);
    settle();

    // zero radius: nothing is ever near
    sender_idle_pct = 23;
    recv_stall_pct  = 23;
    configure(300, 700, 0);
    run_random(30);
    settle();

    configure(700, 250, 64);
    run_random(200);
    settle();

    // hold the output off while whole sets keep arriving
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    configure(200, 200, 100);
    hold_left = 600;
    for (i = 0; i < 12; i++) begin
      s      = random_segment();
      s.last = (i % 2 == 1);
      send_segment(s);
    end
    sender_idle_pct = 23;
    recv_stall_pct  = 23;
    run_random(70);
    settle();

    if (board.close_out() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
design/ssda_pkg.sv
design/ssda_isqrt.sv
design/ssda_cordic.sv
design/segment_select_direction_angle_core.sv
tb/segment_select_direction_angle_core_tb.sv
